// ===== design/rtp_pkg.sv =====
// Shared types, constants and lookup functions of the ringtone note parser.
`timescale 1ns / 1ps
package rtp_pkg;

  localparam int TONE_ENTRIES = 49;

  typedef enum logic [3:0] {
    PH_NAME  = 4'd0,
    PH_KEY   = 4'd1,
    PH_D_EQ  = 4'd2,
    PH_O_EQ  = 4'd3,
    PH_B_EQ  = 4'd4,
    PH_D_NUM = 4'd5,
    PH_O_NUM = 4'd6,
    PH_B_NUM = 4'd7,
    PH_DUR   = 4'd8,
    PH_SHARP = 4'd9,
    PH_DOT   = 4'd10,
    PH_OCT   = 4'd11,
    PH_TAIL  = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_DIV,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic parse;
    logic div_write;
    logic tail;
  } cmd_t;

  typedef struct packed {
    logic emit_old;
    logic need_div;
    logic div_done;
    logic tail_emit;
    logic out_free;
  } sts_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;

  localparam logic [9:0]  DEF_LEN_RST   = 10'd4;
  localparam logic [2:0]  DEF_OCT_RST   = 3'd6;
  localparam logic [17:0] WHOLE_RST     = 18'd3808;
  localparam logic [9:0]  NUM_MAX       = 10'd999;
  localparam logic [17:0] MS_PER_MINUTE = 18'd60000;

  localparam logic [11:0] TONE_TABLE [0:TONE_ENTRIES-1] = '{
    12'd0,    12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
    12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,  12'd523,
    12'd554,  12'd587,  12'd622,  12'd659,  12'd698,  12'd740,  12'd784,
    12'd831,  12'd880,  12'd932,  12'd988,  12'd1047, 12'd1109, 12'd1175,
    12'd1245, 12'd1319, 12'd1397, 12'd1480, 12'd1568, 12'd1661, 12'd1760,
    12'd1865, 12'd1976, 12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637,
    12'd2794, 12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
  };

  function automatic logic [11:0] tone_lookup(input logic [5:0] idx);
    logic [11:0] t;
    t = 12'd0;
    if (idx <= 6'(TONE_ENTRIES - 1)) t = TONE_TABLE[idx];
    return t;
  endfunction

  function automatic logic [3:0] letter_pitch(input logic [7:0] c);
    logic [3:0] p;
    unique case (c)
      CH_C:    p = 4'd1;
      CH_D:    p = 4'd3;
      CH_E:    p = 4'd5;
      CH_F:    p = 4'd6;
      CH_G:    p = 4'd8;
      CH_A:    p = 4'd10;
      CH_B:    p = 4'd12;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic phase_t header_key(input logic [7:0] c);
    phase_t p;
    unique case (c)
      CH_COLON: p = PH_DUR;
      CH_D:     p = PH_D_EQ;
      CH_O:     p = PH_O_EQ;
      CH_B:     p = PH_B_EQ;
      default:  p = PH_KEY;
    endcase
    return p;
  endfunction

endpackage

// ===== design/rtp_if.sv =====
// Valid/ready channel interfaces for song bytes and parsed notes.
`timescale 1ns / 1ps
interface rtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] song_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, song_byte, first_byte, last_byte, input ready);
  modport sink (input valid, song_byte, first_byte, last_byte, output ready);
endinterface

interface rtp_note_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_hz;
  logic [18:0] duration_ms;
  logic        is_rest;
  logic        octave_error;
  logic        song_end;
  modport source (output valid, tone_hz, duration_ms, is_rest, octave_error, song_end,
                  input ready);
  modport sink (input valid, tone_hz, duration_ms, is_rest, octave_error, song_end,
                output ready);
endinterface

// ===== design/rtp_div.sv =====
// Restoring divider, one quotient bit per cycle, 18-bit dividend by 10-bit divisor.
`timescale 1ns / 1ps
module rtp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [17:0] quotient
);

  logic [9:0]  rem;
  logic [9:0]  dsr;
  logic [4:0]  cnt;
  logic [10:0] shifted;
  logic        ge;

  assign shifted = {rem, quotient[17]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd18;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 10'd0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? 10'(shifted - {1'b0, dsr}) : shifted[9:0];
      quotient <= {quotient[16:0], ge};
    end
  end

endmodule

// ===== design/rtp_ctrl.sv =====
// Sequencing state machine: accept, parse, divide, finish, one byte at a time.
`timescale 1ns / 1ps
module rtp_ctrl (
  input  logic            clk,
  input  logic            rst,
  rtp_byte_if.sink        song_in,
  input  rtp_pkg::sts_t   sts,
  output rtp_pkg::cmd_t   cmd
);

  rtp_pkg::state_t state;
  rtp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rtp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rtp_pkg::ST_IDLE:  if (song_in.valid) state_next = rtp_pkg::ST_PARSE;
      rtp_pkg::ST_PARSE: begin
        if (!(sts.emit_old && !sts.out_free)) begin
          state_next = sts.need_div ? rtp_pkg::ST_DIV : rtp_pkg::ST_TAIL;
        end
      end
      rtp_pkg::ST_DIV:   if (sts.div_done) state_next = rtp_pkg::ST_TAIL;
      rtp_pkg::ST_TAIL:  if (!(sts.tail_emit && !sts.out_free)) state_next = rtp_pkg::ST_IDLE;
      default:           state_next = rtp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    song_in.ready = 1'b0;
    unique case (state)
      rtp_pkg::ST_IDLE: begin
        song_in.ready = 1'b1;
        cmd.load      = song_in.valid;
      end
      rtp_pkg::ST_PARSE: cmd.parse     = !(sts.emit_old && !sts.out_free);
      rtp_pkg::ST_DIV:   cmd.div_write = sts.div_done;
      rtp_pkg::ST_TAIL:  cmd.tail      = !(sts.tail_emit && !sts.out_free);
      default: ;
    endcase
  end

endmodule

// ===== design/rtp_datapath.sv =====
// Parse state, note fields, duration divider and the result register.
`timescale 1ns / 1ps
module rtp_datapath (
  input  logic           clk,
  input  logic           rst,
  input  rtp_pkg::cmd_t  cmd,
  output rtp_pkg::sts_t  sts,
  input  logic [7:0]     song_byte,
  input  logic           first_byte,
  input  logic           last_byte,
  rtp_note_if.source     note_out
);

  rtp_pkg::phase_t phase;
  rtp_pkg::phase_t phase_next;
  logic [9:0]  def_len, def_len_next;
  logic [2:0]  def_oct, def_oct_next;
  logic [17:0] whole_ms;
  logic [9:0]  acc, acc_next;
  logic [3:0]  pitch, pitch_next;
  logic [18:0] note_len, note_len_next;
  logic [3:0]  note_oct, note_oct_next;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        div_bpm, div_bpm_next;

  logic        is_dig;
  logic [3:0]  dval;
  logic [13:0] acc_mul;
  logic [9:0]  acc_sat;
  logic        emit_old, need_div, letter;
  logic [9:0]  div_in;
  logic [9:0]  acc_eff;
  logic [9:0]  letter_div;

  logic        div_busy, div_done;
  logic [17:0] quotient;

  logic [6:0]  tsum;
  logic        tone_ok;
  logic        load_out;
  logic        end_flag;

  assign is_dig  = (byte_r >= rtp_pkg::CH_ZERO) && (byte_r <= rtp_pkg::CH_NINE);
  assign dval    = byte_r[3:0];
  assign acc_mul = 14'(acc) * 14'd10 + 14'(dval);
  assign acc_sat = (acc_mul > 14'(rtp_pkg::NUM_MAX)) ? rtp_pkg::NUM_MAX : acc_mul[9:0];

  // A letter after an ended note starts from an empty length number.
  assign acc_eff    = (phase == rtp_pkg::PH_DUR) ? acc : 10'd0;
  assign letter_div = (acc_eff != 10'd0) ? acc_eff :
                      ((def_len != 10'd0) ? def_len : 10'd1);

  always_comb begin
    phase_next    = phase;
    def_len_next  = def_len;
    def_oct_next  = def_oct;
    acc_next      = acc;
    pitch_next    = pitch;
    note_len_next = note_len;
    note_oct_next = note_oct;
    emit_old      = 1'b0;
    need_div      = 1'b0;
    letter        = 1'b0;
    div_bpm_next  = 1'b0;
    div_in        = letter_div;
    unique case (phase) inside
      rtp_pkg::PH_KEY: begin
        phase_next = rtp_pkg::header_key(byte_r);
        if (byte_r == rtp_pkg::CH_COLON) acc_next = 10'd0;
      end
      rtp_pkg::PH_D_EQ: begin
        phase_next = rtp_pkg::PH_D_NUM;
        acc_next   = 10'd0;
      end
      rtp_pkg::PH_O_EQ: begin
        phase_next = rtp_pkg::PH_O_NUM;
        acc_next   = 10'd0;
      end
      rtp_pkg::PH_B_EQ: begin
        phase_next = rtp_pkg::PH_B_NUM;
        acc_next   = 10'd0;
      end
      rtp_pkg::PH_D_NUM: begin
        if (is_dig) acc_next = acc_sat;
        else begin
          if (acc != 10'd0) def_len_next = acc;
          phase_next = rtp_pkg::header_key(byte_r);
          if (byte_r == rtp_pkg::CH_COLON) acc_next = 10'd0;
        end
      end
      rtp_pkg::PH_O_NUM: begin
        if (is_dig) begin
          if (dval >= 4'd3 && dval <= 4'd7) def_oct_next = dval[2:0];
          phase_next = rtp_pkg::PH_KEY;
        end else begin
          phase_next = rtp_pkg::header_key(byte_r);
          if (byte_r == rtp_pkg::CH_COLON) acc_next = 10'd0;
        end
      end
      rtp_pkg::PH_B_NUM: begin
        if (is_dig) acc_next = acc_sat;
        else begin
          if (acc != 10'd0) begin
            need_div     = 1'b1;
            div_bpm_next = 1'b1;
            div_in       = acc;
          end
          phase_next = rtp_pkg::header_key(byte_r);
          if (byte_r == rtp_pkg::CH_COLON) acc_next = 10'd0;
        end
      end
      rtp_pkg::PH_DUR: begin
        if (is_dig) acc_next = acc_sat;
        else letter = 1'b1;
      end
      rtp_pkg::PH_SHARP, rtp_pkg::PH_DOT, rtp_pkg::PH_OCT, rtp_pkg::PH_TAIL: begin
        if (byte_r == rtp_pkg::CH_SHARP && phase == rtp_pkg::PH_SHARP) begin
          if (pitch != 4'd0) pitch_next = pitch + 4'd1;
          phase_next = rtp_pkg::PH_DOT;
        end else if (byte_r == rtp_pkg::CH_DOT && phase <= rtp_pkg::PH_DOT) begin
          note_len_next = note_len + (note_len >> 1);
          phase_next    = rtp_pkg::PH_OCT;
        end else if (is_dig && phase <= rtp_pkg::PH_OCT) begin
          note_oct_next = dval;
          phase_next    = rtp_pkg::PH_TAIL;
        end else begin
          // The note ends here; the same byte opens the next one.
          emit_old   = 1'b1;
          phase_next = rtp_pkg::PH_DUR;
          acc_next   = 10'd0;
          if (byte_r != rtp_pkg::CH_COMMA) begin
            if (is_dig) acc_next = 10'(dval);
            else letter = 1'b1;
          end
        end
      end
      default: begin
        phase_next = (byte_r == rtp_pkg::CH_COLON) ? rtp_pkg::PH_KEY : rtp_pkg::PH_NAME;
      end
    endcase
    if (letter) begin
      need_div      = 1'b1;
      pitch_next    = rtp_pkg::letter_pitch(byte_r);
      note_oct_next = {1'b0, def_oct};
      acc_next      = 10'd0;
      phase_next    = rtp_pkg::PH_SHARP;
    end
  end

  rtp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.parse && need_div),
    .dividend (div_bpm_next ? rtp_pkg::MS_PER_MINUTE : whole_ms),
    .divisor  (div_in),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst || (cmd.load && first_byte)) begin
      phase    <= rtp_pkg::PH_NAME;
      def_len  <= rtp_pkg::DEF_LEN_RST;
      def_oct  <= rtp_pkg::DEF_OCT_RST;
      whole_ms <= rtp_pkg::WHOLE_RST;
      acc      <= 10'd0;
      pitch    <= 4'd0;
      note_len <= 19'd0;
      note_oct <= {1'b0, rtp_pkg::DEF_OCT_RST};
    end else if (cmd.parse) begin
      phase    <= phase_next;
      def_len  <= def_len_next;
      def_oct  <= def_oct_next;
      acc      <= acc_next;
      pitch    <= pitch_next;
      note_len <= note_len_next;
      note_oct <= note_oct_next;
    end else if (cmd.div_write) begin
      if (div_bpm) whole_ms <= {quotient[15:0], 2'b00};
      else         note_len <= {1'b0, quotient};
    end else if (cmd.tail && last_r) begin
      phase <= rtp_pkg::PH_NAME;
      acc   <= 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= song_byte;
      last_r <= last_byte;
    end
    if (cmd.parse && need_div) div_bpm <= div_bpm_next;
  end

  // Table index is (octave - 4) * 12 + pitch; valid entries sit at 1..48.
  assign tsum    = 7'(note_oct) * 7'd12 + 7'(pitch);
  assign tone_ok = (tsum >= 7'd49) && (tsum <= 7'd96);

  assign sts.emit_old  = emit_old;
  assign sts.need_div  = need_div;
  assign sts.div_done  = div_done;
  assign sts.tail_emit = last_r && (phase >= rtp_pkg::PH_SHARP) && (phase <= rtp_pkg::PH_TAIL);
  assign sts.out_free  = !note_out.valid || note_out.ready;

  assign load_out = (cmd.parse && emit_old) || (cmd.tail && sts.tail_emit);
  // The ended note carries the end mark unless a new note also closes on this byte.
  assign end_flag = cmd.tail ? 1'b1 : (last_r && !letter);

  always_ff @(posedge clk) begin
    if (rst) note_out.valid <= 1'b0;
    else if (load_out) note_out.valid <= 1'b1;
    else if (note_out.ready) note_out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      note_out.duration_ms  <= note_len;
      note_out.is_rest      <= (pitch == 4'd0);
      note_out.octave_error <= (pitch != 4'd0) && !tone_ok;
      note_out.tone_hz      <= ((pitch != 4'd0) && tone_ok) ?
                               rtp_pkg::tone_lookup(6'(tsum - 7'd48)) : 12'd0;
      note_out.song_end     <= end_flag;
    end
  end

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.parse && need_div) |-> !div_busy)
    else $error("divider started while busy");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!note_out.valid || note_out.ready))
    else $error("result register overwritten");

  a_last_to_name: assert property (@(posedge clk) disable iff (rst)
    (cmd.tail && last_r && !(cmd.load && first_byte)) |=> (phase == rtp_pkg::PH_NAME))
    else $error("parse did not return to the name field after the last byte");

endmodule

// ===== design/rtttl_note_parser_core.sv =====
// Top level of the ringtone note parser: controller, datapath and channel ports.
//
// song_in carries one text byte per transaction with first_byte and last_byte
// marks; note_out carries one parsed note per transaction (tone, length in ms,
// rest, bad-octave and end-of-song flags). A byte may yield zero, one or two
// notes.
// A byte is taken in the idle state and then parsed. A byte that begins a
// note letter, or closes the tempo field, then runs the restoring divider;
// other bytes go straight to the finish step. A new byte is taken only after
// the previous one has been through all its steps.
// A result is loaded into the output register by the step that
// closes its note and stays there until the receiver takes it; while the
// register is full and another note ends, the parser waits in that step and
// song_in ready stays low.
// Reset (rst, synchronous) returns the parser to the name field with length 4,
// octave 6 and tempo 63, and empties the output register.
`timescale 1ns / 1ps
module rtttl_note_parser_core (
  input  logic        clk,
  input  logic        rst,
  rtp_byte_if.sink    song_in,
  rtp_note_if.source  note_out
);

  rtp_pkg::cmd_t cmd;
  rtp_pkg::sts_t sts;

  rtp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .song_in (song_in),
    .sts     (sts),
    .cmd     (cmd)
  );

  rtp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .song_byte  (song_in.song_byte),
    .first_byte (song_in.first_byte),
    .last_byte  (song_in.last_byte),
    .note_out   (note_out)
  );

endmodule
